/* hw/rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, register map and fixed-point helpers of the layer compositor.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int unsigned NumStages  = 10;
  localparam int unsigned LaneStages = 5;
  localparam int unsigned AddrWidth  = 3;

  localparam logic [8:0]  OpacityUnity = 9'd256;
  localparam logic [16:0] AlphaUnity   = 17'h10000;
  // ceil(2^32 / 255), exact for dividends below 16909320
  localparam logic [24:0] Recip255     = 25'd16843010;

  typedef enum logic [3:0] {
    BM_NORMAL     = 4'd0,
    BM_MULTIPLY   = 4'd1,
    BM_ADD        = 4'd2,
    BM_BURN       = 4'd3,
    BM_DODGE      = 4'd4,
    BM_REFLECT    = 4'd5,
    BM_GLOW       = 4'd6,
    BM_OVERLAY    = 4'd7,
    BM_DIFFERENCE = 4'd8,
    BM_NEGATION   = 4'd9,
    BM_LIGHTEN    = 4'd10,
    BM_DARKEN     = 4'd11,
    BM_SCREEN     = 4'd12,
    BM_XOR        = 4'd13
  } blend_mode_e;

  typedef enum logic [0:0] {
    REG_OPACITY = 1'b0,
    REG_MODE    = 1'b1
  } reg_index_e;

  // floor(v / 255) by reciprocal multiply
  function automatic logic [16:0] div255(logic [24:0] v);
    logic [49:0] prod;
    prod = 50'(v) * 50'(Recip255);
    return prod[48:32];
  endfunction

  function automatic logic [7:0] sat8(logic [8:0] v);
    return v[8] ? 8'd255 : v[7:0];
  endfunction

endpackage

/* hw/rtl/lbc_blend_lane.sv */
// ----------------------------------------------------------------------------
// lbc_blend_lane
// Pipelined blend value of one color channel, with a two-bit-per-stage divider.
// ----------------------------------------------------------------------------
module lbc_blend_lane (
  input  logic                                clk_i,
  input  logic [lbc_pkg::LaneStages-1:0]      en_i,
  input  lbc_pkg::blend_mode_e                mode_i,
  input  logic [7:0]                          s_i,
  input  logic [7:0]                          d_i,
  output logic [7:0]                          m_o
);
  import lbc_pkg::*;

  typedef struct packed {
    logic [7:0]  s;
    logic [7:0]  d;
    logic [16:0] prod;
    logic [8:0]  pm;
    logic [16:0] rem;
    logic [8:0]  dv;
    logic [7:0]  quo;
    logic        sat;
    logic [7:0]  m;
  } lane_t;

  lane_t lane_q [LaneStages];
  lane_t lane_d [LaneStages];

  function automatic lane_t div_bit(lane_t x, logic [2:0] b);
    lane_t       y;
    logic [16:0] sh;
    y  = x;
    sh = {8'b0, x.dv} << b;
    if (x.rem >= sh) begin
      y.rem    = x.rem - sh;
      y.quo[b] = 1'b1;
    end
    return y;
  endfunction

  always_comb begin
    logic [7:0]  sc, dc, qc, dif, ng;
    logic [15:0] num;
    logic [7:0]  den;
    logic [8:0]  sum;

    // stage 0: products and divider operands
    lane_d[0]     = lane_q[0];
    sc            = 8'd255 - s_i;
    dc            = 8'd255 - d_i;
    num           = '0;
    den           = '0;
    lane_d[0].s   = s_i;
    lane_d[0].d   = d_i;
    lane_d[0].prod = '0;
    unique case (mode_i)
      BM_MULTIPLY: lane_d[0].prod = 17'(s_i) * 17'(d_i);
      BM_OVERLAY: begin
        if (d_i < 8'd128) begin
          lane_d[0].prod = (17'(s_i) * 17'(d_i)) << 1;
        end else begin
          lane_d[0].prod = (17'(sc) * 17'(dc)) << 1;
        end
      end
      BM_SCREEN:  lane_d[0].prod = 17'(sc) * 17'(dc);
      BM_BURN: begin
        num = 16'(dc) * 16'd255;
        den = s_i;
      end
      BM_DODGE: begin
        num = 16'(d_i) * 16'd255;
        den = sc;
      end
      BM_REFLECT: begin
        num = 16'(d_i) * 16'(d_i);
        den = sc;
      end
      BM_GLOW: begin
        num = 16'(s_i) * 16'(s_i);
        den = dc;
      end
      default: ;
    endcase
    // round half up: (2n + q) / (2q)
    lane_d[0].rem = {num, 1'b0} + 17'(den);
    lane_d[0].dv  = {den, 1'b0};
    lane_d[0].quo = '0;
    lane_d[0].sat = 1'b0;

    // stage 1: scale by 1/255, saturation check, quotient bits 7 and 6
    lane_d[1]     = lane_q[0];
    lane_d[1].pm  = 9'(div255(25'(lane_q[0].prod) + 25'd127));
    lane_d[1].sat = lane_q[0].rem >= {lane_q[0].dv, 8'b0};
    lane_d[1]     = div_bit(lane_d[1], 3'd7);
    lane_d[1]     = div_bit(lane_d[1], 3'd6);

    lane_d[2]     = div_bit(div_bit(lane_q[1], 3'd5), 3'd4);
    lane_d[3]     = div_bit(div_bit(lane_q[2], 3'd3), 3'd2);

    // stage 4: last bits, then pick the blend value
    lane_d[4] = div_bit(div_bit(lane_q[3], 3'd1), 3'd0);
    qc  = lane_d[4].sat ? 8'd255 : lane_d[4].quo;
    sum = 9'(lane_q[3].s) + 9'(lane_q[3].d);
    dif = (lane_q[3].d > lane_q[3].s) ? lane_q[3].d - lane_q[3].s
                                      : lane_q[3].s - lane_q[3].d;
    ng  = sum > 9'd255 ? 8'(sum - 9'd255) : 8'(9'd255 - sum);
    unique case (mode_i)
      BM_MULTIPLY:   lane_d[4].m = sat8(lane_q[3].pm);
      BM_ADD:        lane_d[4].m = sat8(sum);
      BM_BURN:       lane_d[4].m = (lane_q[3].s == 8'd0) ? 8'd0 : 8'd255 - qc;
      BM_DODGE,
      BM_REFLECT:    lane_d[4].m = (lane_q[3].s == 8'd255) ? 8'd255 : qc;
      BM_GLOW:       lane_d[4].m = (lane_q[3].d == 8'd255) ? 8'd255 : qc;
      BM_OVERLAY: begin
        if (lane_q[3].d < 8'd128) begin
          lane_d[4].m = sat8(lane_q[3].pm);
        end else begin
          lane_d[4].m = 8'd255 - sat8(lane_q[3].pm);
        end
      end
      BM_DIFFERENCE: lane_d[4].m = dif;
      BM_NEGATION:   lane_d[4].m = 8'd255 - ng;
      BM_LIGHTEN:    lane_d[4].m = (lane_q[3].s > lane_q[3].d) ? lane_q[3].s : lane_q[3].d;
      BM_DARKEN:     lane_d[4].m = (lane_q[3].s < lane_q[3].d) ? lane_q[3].s : lane_q[3].d;
      BM_SCREEN:     lane_d[4].m = 8'd255 - sat8(lane_q[3].pm);
      BM_XOR:        lane_d[4].m = lane_q[3].s ^ lane_q[3].d;
      default:       lane_d[4].m = lane_q[3].s;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LaneStages; k++) begin
      if (en_i[k]) begin
        lane_q[k] <= lane_d[k];
      end
    end
  end

  assign m_o = lane_q[LaneStages-1].m;

endmodule

/* hw/rtl/layer_blend_compositor.sv */
// Throughput: one pixel per cycle while the output is ready; every stage holds under backpressure.
// The final per-channel divide by the output alpha sets the depth: three
// register stages of three quotient bits each, after the blend lanes' divider.
// Reset clears all stage valid bits; opacity resets to 256, blend mode to normal.
// ----------------------------------------------------------------------------
// layer_blend_compositor
// Source-over compositing of a BGRA source word onto a BGRA destination word
// with layer opacity and fourteen blend modes, with an APB register port.
// ----------------------------------------------------------------------------
module layer_blend_compositor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbc_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     src_blue_i,
  input  logic [7:0]                     src_green_i,
  input  logic [7:0]                     src_red_i,
  input  logic [7:0]                     src_alpha_i,
  input  logic [7:0]                     dst_blue_i,
  input  logic [7:0]                     dst_green_i,
  input  logic [7:0]                     dst_red_i,
  input  logic [7:0]                     dst_alpha_i,
  // pixel output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_blue_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_alpha_o
);
  import lbc_pkg::*;

  typedef struct packed {
    logic [28:0] rem;
    logic [8:0]  quo;
  } fdiv_t;

  typedef struct packed {
    logic [2:0][7:0]  src;
    logic [3:0][7:0]  dst;
    logic [16:0]      a_op;
    logic [16:0]      a;
    logic [16:0]      da;
    logic             zero;
    logic [33:0]      p;
    logic [16:0]      oa;
    logic [7:0]       alpha;
    logic [2:0][24:0] w1s;
    logic [2:0][41:0] pd;
    logic [2:0][25:0] x;
    logic [2:0][43:0] num;
    fdiv_t [2:0]      fd;
    logic [3:0][7:0]  res;
  } stage_t;

  // --------------------------------------------------------------------------
  // Register file. Writes land on the access phase; reads are combinational.
  // --------------------------------------------------------------------------
  logic [8:0] opacity_q;
  logic [3:0] mode_q;
  logic [8:0] op_sat;
  reg_index_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= OpacityUnity;
      mode_q    <= BM_NORMAL;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_OPACITY: opacity_q <= pwdata[8:0];
        REG_MODE:    mode_q    <= pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OPACITY: prdata = {23'b0, opacity_q};
      REG_MODE:    prdata = {28'b0, mode_q};
      default:     prdata = '0;
    endcase
  end

  // opacity above unity saturates
  assign op_sat = (opacity_q > OpacityUnity) ? OpacityUnity : opacity_q;

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its word moves on.
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vin;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] ld;

  assign vin = {vld_q[NumStages-2:0], in_valid_i};

  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld = rdy[NumStages-1:0] & vin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  // --------------------------------------------------------------------------
  // Blend lanes: one per color channel, blend value ready at stage 4.
  // --------------------------------------------------------------------------
  logic [2:0][7:0] src_ch;
  logic [2:0][7:0] dst_ch;
  logic [2:0][7:0] blend_m;

  assign src_ch = {src_red_i, src_green_i, src_blue_i};
  assign dst_ch = {dst_red_i, dst_green_i, dst_blue_i};

  for (genvar c = 0; c < 3; c++) begin : g_lane
    lbc_blend_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (ld[LaneStages-1:0]),
      .mode_i (blend_mode_e'(mode_q)),
      .s_i    (src_ch[c]),
      .d_i    (dst_ch[c]),
      .m_o    (blend_m[c])
    );
  end

  // --------------------------------------------------------------------------
  // Alpha and compositing datapath.
  // --------------------------------------------------------------------------
  stage_t stg_q [NumStages];
  stage_t stg_d [NumStages];

  // one restoring quotient bit of T / oa
  function automatic fdiv_t fdiv_bit(fdiv_t x, logic [16:0] oa, logic [3:0] b);
    fdiv_t       y;
    logic [28:0] sh;
    y  = x;
    sh = {12'b0, oa} << b;
    if (x.rem >= sh) begin
      y.rem    = x.rem - sh;
      y.quo[b] = 1'b1;
    end
    return y;
  endfunction

  always_comb begin
    logic [44:0] tsum;
    logic [24:0] asc;

    // stage 0: capture the word, source alpha times opacity
    stg_d[0]      = stg_q[0];
    stg_d[0].src  = src_ch;
    stg_d[0].dst  = {dst_alpha_i, dst_ch};
    stg_d[0].a_op = 17'(src_alpha_i) * 17'(op_sat);

    // stage 1: effective alpha and destination alpha in Q0.16
    stg_d[1]      = stg_q[0];
    stg_d[1].a    = div255({stg_q[0].a_op[16:0], 8'b0} + 25'd127);
    stg_d[1].da   = div255({1'b0, stg_q[0].dst[3], 16'b0} + 25'd127);
    stg_d[1].zero = (stg_d[1].a == '0);

    // stage 2: da * (1 - a), and s * (1 - da)
    stg_d[2]   = stg_q[1];
    stg_d[2].p = 34'(stg_q[1].da) * 34'(AlphaUnity - stg_q[1].a);
    for (int c = 0; c < 3; c++) begin
      stg_d[2].w1s[c] = 25'(stg_q[1].src[c]) * 25'(AlphaUnity - stg_q[1].da);
    end

    // stage 3: output alpha, destination term
    stg_d[3]    = stg_q[2];
    stg_d[3].oa = stg_q[2].a + 17'((35'(stg_q[2].p) + 35'd32768) >> 16);
    for (int c = 0; c < 3; c++) begin
      stg_d[3].pd[c] = 42'(stg_q[2].p) * 42'(stg_q[2].dst[c]);
    end

    // stage 4: output alpha back to 0..255
    stg_d[4]       = stg_q[3];
    asc            = 25'(stg_q[3].oa) * 25'd255 + 25'd32768;
    stg_d[4].alpha = sat8(asc[24:16]);

    // stage 5: fold in the blend value
    stg_d[5] = stg_q[4];
    for (int c = 0; c < 3; c++) begin
      stg_d[5].x[c] = 26'(stg_q[4].w1s[c]) + 26'(stg_q[4].da) * 26'(blend_m[c]);
    end

    // stage 6: full numerator
    stg_d[6] = stg_q[5];
    for (int c = 0; c < 3; c++) begin
      stg_d[6].num[c] = 44'(stg_q[5].a) * 44'(stg_q[5].x[c]) + 44'(stg_q[5].pd[c]);
    end

    // stage 7: drop the Q0.16 scale with rounding, quotient bits 8..6
    stg_d[7] = stg_q[6];
    for (int c = 0; c < 3; c++) begin
      tsum = 45'(stg_q[6].num[c]) + {13'b0, stg_q[6].oa, 15'b0};
      stg_d[7].fd[c].rem = tsum[44:16];
      stg_d[7].fd[c].quo = '0;
      for (int b = 8; b >= 6; b--) begin
        stg_d[7].fd[c] = fdiv_bit(stg_d[7].fd[c], stg_q[6].oa, 4'(b));
      end
    end

    // stage 8: quotient bits 5..3
    stg_d[8] = stg_q[7];
    for (int c = 0; c < 3; c++) begin
      for (int b = 5; b >= 3; b--) begin
        stg_d[8].fd[c] = fdiv_bit(stg_d[8].fd[c], stg_q[7].oa, 4'(b));
      end
    end

    // stage 9: quotient bits 2..0, clamp, pass the destination through at zero alpha
    stg_d[9] = stg_q[8];
    for (int c = 0; c < 3; c++) begin
      for (int b = 2; b >= 0; b--) begin
        stg_d[9].fd[c] = fdiv_bit(stg_d[9].fd[c], stg_q[8].oa, 4'(b));
      end
      stg_d[9].res[c] = stg_q[8].zero ? stg_q[8].dst[c] : sat8(stg_d[9].fd[c].quo);
    end
    stg_d[9].res[3] = stg_q[8].zero ? stg_q[8].dst[3] : stg_q[8].alpha;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ld[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_blue_o  = stg_q[NumStages-1].res[0];
  assign out_green_o = stg_q[NumStages-1].res[1];
  assign out_red_o   = stg_q[NumStages-1].res[2];
  assign out_alpha_o = stg_q[NumStages-1].res[3];

endmodule
